// ----- rtl/sfs_pkg.sv -----
// sfs_pkg: shared types and constants of the screen fade sequencer
// used by every rtl file of the block; depends on nothing

package sfs_pkg;

    localparam int WORD_W      = 16;
    localparam int KIND_W      = 3;
    localparam int DELAY_W     = 3;
    localparam int LEVEL_OUT_W = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [DELAY_W-1:0] IN_DELAY   = 3'd5;
    localparam logic [DELAY_W-1:0] OUT_DELAY  = 3'd4;
    localparam int                 QUICK_STEP = 4;

    localparam logic [WORD_W-1:0] DARKEN_RESET = 16'd255;

    // register index of darken_control
    localparam logic REG_DARKEN = 1'b0;

    typedef enum logic [KIND_W-1:0] {
        KIND_START_IN  = 3'd0,
        KIND_START_OUT = 3'd1,
        KIND_SLOW_IN   = 3'd2,
        KIND_QUICK_IN  = 3'd3,
        KIND_OUT_TICK  = 3'd4,
        KIND_END       = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [WORD_W-1:0] restore_control;
        logic [WORD_W-1:0] restore_alpha;
    } item_t;

    typedef struct packed {
        logic [LEVEL_OUT_W-1:0] level;
        logic [WORD_W-1:0]      blend_control;
        logic [WORD_W-1:0]      blend_alpha;
        logic                   fading;
        logic                   busy_res;
        logic                   black_done;
    } result_t;

endpackage

// ----- rtl/sfs_in_if.sv -----
// sfs_in_if: command and tick channel of the screen fade sequencer
// valid/ready handshake with the item fields; depends on sfs_pkg

interface sfs_in_if;

    logic                       valid;
    logic                       ready;
    logic [sfs_pkg::KIND_W-1:0] kind;
    logic [sfs_pkg::WORD_W-1:0] restore_control;
    logic [sfs_pkg::WORD_W-1:0] restore_alpha;

    modport source (output valid, output kind, output restore_control,
                    output restore_alpha, input ready);
    modport sink (input valid, input kind, input restore_control,
                  input restore_alpha, output ready);

endinterface

// ----- rtl/sfs_out_if.sv -----
// sfs_out_if: result channel of the screen fade sequencer
// valid/ready handshake with the result fields; depends on sfs_pkg

interface sfs_out_if;

    logic                            valid;
    logic                            ready;
    logic [sfs_pkg::LEVEL_OUT_W-1:0] level;
    logic [sfs_pkg::WORD_W-1:0]      blend_control;
    logic [sfs_pkg::WORD_W-1:0]      blend_alpha;
    logic                            fading;
    logic                            busy_res;
    logic                            black_done;

    modport source (output valid, output level, output blend_control,
                    output blend_alpha, output fading, output busy_res,
                    output black_done, input ready);
    modport sink (input valid, input level, input blend_control,
                  input blend_alpha, input fading, input busy_res,
                  input black_done, output ready);

endinterface

// ----- rtl/screen_fade_sequencer.sv -----
// screen_fade_sequencer: top level of the display brightness fade sequencer
// depends on sfs_pkg, sfs_in_if, sfs_out_if, sfs_cfg and sfs_step
//
// usage
//   in_ch carries one command or frame tick per beat (kind, restore words);
//   out_ch returns exactly one result beat per input beat, in order.
//   the user writes darken_control over the apb port at byte address 0 only
//   while the block is idle; the block does not enforce it; pready is always high.
// registers and throughput
//   a beat taken lands in the input register, and its result is then
//   registered in the output register, where out_ch.valid rises; a stall on
//   out_ch.ready can hold the beat in the input register between the two.
//   one beat per cycle is sustained while out_ch.ready stays high; each beat
//   updates the 5-bit level and 3-bit delay registers.
// reset
//   rst_n clears the level, delay, fade flag, saved and image words and
//   both valid flags; darken_control returns to 255.
// stalls
//   while out_ch.ready is low the result holds; the input register still
//   takes one more beat, then in_ch.ready drops until the result leaves.

module screen_fade_sequencer
#(
    parameter int MAX_LEVEL = 31
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    sfs_in_if.sink                              in_ch,
    sfs_out_if.source                           out_ch,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [sfs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sfs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic                       in_vld_reg,  in_vld_next;
    sfs_pkg::item_t             in_item_reg;
    logic                       out_vld_reg, out_vld_next;
    sfs_pkg::result_t           out_res_reg;
    sfs_pkg::result_t           step_res;
    logic [sfs_pkg::WORD_W-1:0] darken_control;
    logic                       out_free;
    logic                       advance;
    logic                       in_take;

    sfs_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .darken_control (darken_control)
    );

    sfs_step #(.MAX_LEVEL(MAX_LEVEL)) u_step
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (advance),
        .item           (in_item_reg),
        .darken_control (darken_control),
        .res            (step_res)
    );

    assign out_free    = !out_vld_reg || out_ch.ready;
    assign advance     = in_vld_reg && out_free;
    assign in_ch.ready = !in_vld_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind            <= sfs_pkg::kind_t'(in_ch.kind);
            in_item_reg.restore_control <= in_ch.restore_control;
            in_item_reg.restore_alpha   <= in_ch.restore_alpha;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_ch.valid         = out_vld_reg;
    assign out_ch.level         = out_res_reg.level;
    assign out_ch.blend_control = out_res_reg.blend_control;
    assign out_ch.blend_alpha   = out_res_reg.blend_alpha;
    assign out_ch.fading        = out_res_reg.fading;
    assign out_ch.busy_res      = out_res_reg.busy_res;
    assign out_ch.black_done    = out_res_reg.black_done;

endmodule

// ----- rtl/sfs_cfg.sv -----
// sfs_cfg: apb register file holding darken_control
// depends on sfs_pkg

module sfs_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sfs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sfs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sfs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output logic [sfs_pkg::WORD_W-1:0]         darken_control
);

    logic [sfs_pkg::WORD_W-1:0] darken_reg;
    logic [sfs_pkg::WORD_W-1:0] darken_next;
    logic                       sel_darken;

    // register index is paddr[2], byte lanes ignored
    assign sel_darken = (paddr[2] == sfs_pkg::REG_DARKEN);
    assign pready     = 1'b1;

    always_comb
    begin
        darken_next = darken_reg;
        if (psel && penable && pwrite && sel_darken)
        begin
            darken_next = pwdata[sfs_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            darken_reg <= sfs_pkg::DARKEN_RESET;
        end
        else
        begin
            darken_reg <= darken_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_darken)
        begin
            prdata = {{(sfs_pkg::APB_DATA_W-sfs_pkg::WORD_W){1'b0}}, darken_reg};
        end
    end

    assign darken_control = darken_reg;

endmodule

// ----- rtl/sfs_step.sv -----
// sfs_step: fade state registers and the per-item update logic
// depends on sfs_pkg

module sfs_step
#(
    parameter int MAX_LEVEL = 31
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  sfs_pkg::item_t             item,
    input  logic [sfs_pkg::WORD_W-1:0] darken_control,
    output sfs_pkg::result_t           res
);

    localparam int LW = $clog2(MAX_LEVEL + 1);
    localparam logic [LW-1:0] LEVEL_MAX = LW'(MAX_LEVEL);
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1);
    localparam logic [LW-1:0] STEP_Q    = LW'(sfs_pkg::QUICK_STEP);
    localparam logic [sfs_pkg::DELAY_W-1:0] DELAY_ONE = sfs_pkg::DELAY_W'(1);

    logic [LW-1:0]               level_reg,   level_next;
    logic [sfs_pkg::DELAY_W-1:0] delay_reg,   delay_next;
    logic                        active_reg,  active_next;
    logic [sfs_pkg::WORD_W-1:0]  sctl_reg,    sctl_next;
    logic [sfs_pkg::WORD_W-1:0]  salpha_reg,  salpha_next;
    logic [sfs_pkg::WORD_W-1:0]  ctl_reg,     ctl_next;
    logic [sfs_pkg::WORD_W-1:0]  alpha_reg,   alpha_next;
    logic                        busy;
    logic                        done;
    logic                        finish;

    always_comb
    begin
        level_next  = level_reg;
        delay_next  = delay_reg;
        active_next = active_reg;
        sctl_next   = sctl_reg;
        salpha_next = salpha_reg;
        ctl_next    = ctl_reg;
        alpha_next  = alpha_reg;
        busy        = 1'b0;
        done        = 1'b0;
        finish      = 1'b0;
        case (item.kind)
            sfs_pkg::KIND_START_IN:
            begin
                level_next  = LEVEL_MAX;
                delay_next  = sfs_pkg::IN_DELAY;
                active_next = 1'b1;
                sctl_next   = item.restore_control;
                salpha_next = item.restore_alpha;
                ctl_next    = darken_control;
                alpha_next  = '0;
            end
            sfs_pkg::KIND_START_OUT:
            begin
                level_next = '0;
                delay_next = sfs_pkg::OUT_DELAY;
                ctl_next   = darken_control;
            end
            sfs_pkg::KIND_SLOW_IN:
            begin
                if (active_reg)
                begin
                    if (delay_reg != '0)
                    begin
                        delay_next = delay_reg - DELAY_ONE;
                        busy       = 1'b1;
                    end
                    else if (level_reg > LEVEL_ONE)
                    begin
                        level_next = level_reg - LEVEL_ONE;
                        busy       = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            sfs_pkg::KIND_QUICK_IN:
            begin
                if (active_reg)
                begin
                    if (level_reg == '0)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        level_next = (level_reg > STEP_Q) ? level_reg - STEP_Q : '0;
                        busy       = 1'b1;
                    end
                end
            end
            sfs_pkg::KIND_OUT_TICK:
            begin
                if (level_reg < LEVEL_MAX)
                begin
                    level_next = level_reg + LEVEL_ONE;
                end
                else if (delay_reg != '0)
                begin
                    delay_next = delay_reg - DELAY_ONE;
                end
                else
                begin
                    level_next = LEVEL_MAX;
                    done       = 1'b1;
                end
            end
            sfs_pkg::KIND_END:
            begin
                finish = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
        if (finish)
        begin
            active_next = 1'b0;
            level_next  = '0;
            ctl_next    = sctl_reg;
            alpha_next  = salpha_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            delay_reg  <= '0;
            active_reg <= 1'b0;
            sctl_reg   <= '0;
            salpha_reg <= '0;
            ctl_reg    <= '0;
            alpha_reg  <= '0;
        end
        else if (fire)
        begin
            level_reg  <= level_next;
            delay_reg  <= delay_next;
            active_reg <= active_next;
            sctl_reg   <= sctl_next;
            salpha_reg <= salpha_next;
            ctl_reg    <= ctl_next;
            alpha_reg  <= alpha_next;
        end
    end

    // level port is 5 bits wide whatever the level range
    always_comb
    begin
        res.level         = sfs_pkg::LEVEL_OUT_W'({{sfs_pkg::LEVEL_OUT_W{1'b0}}, level_next});
        res.blend_control = ctl_next;
        res.blend_alpha   = alpha_next;
        res.fading        = active_next;
        res.busy_res      = busy;
        res.black_done    = done;
    end

endmodule
